[rtl/assert_macros.svh]
// assertion macros for the rtl, used by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PMS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PMS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[rtl/pms_pkg.sv]
// types, constants and root table for the preset morph sweep
`default_nettype none
package pms_pkg;

   localparam int MAX_COMPONENTS = 32;
   localparam int SLOT_W         = 5;
   localparam int CNT_W          = 6;
   localparam int STEP_W         = 10;
   localparam int CURVE_W        = 16;
   localparam int MODE_W         = 2;
   localparam int DUR_W          = 22;
   localparam int DATA_W         = 32;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 22;
   localparam int DIV_W          = 42;
   localparam int DIV_CNT_W      = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COMP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 3'd4;

   localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic KIND_VALUE = 1'b0;
   localparam logic KIND_SCHED = 1'b1;

   localparam logic [CURVE_W-1:0] CURVE_LINEAR = 16'd4096;
   localparam logic [DATA_W-1:0]  ONE_Q31      = 32'h8000_0000;

   typedef struct packed {
      logic                     cmd;
      logic [SLOT_W-1:0]        slot;
      logic signed [DATA_W-1:0] start_value;
      logic signed [DATA_W-1:0] end_value;
      logic [DATA_W-1:0]        now_time;
      logic                     transport_running;
   } req_item_type;

   typedef struct packed {
      logic                     kind;
      logic [SLOT_W-1:0]        component;
      logic signed [DATA_W-1:0] morph_value;
      logic [DATA_W-1:0]        event_time;
      logic [DATA_W-1:0]        next_wake;
      logic                     finished;
      logic                     last;
   } rsp_item_type;

   typedef struct packed {
      logic [CNT_W-1:0]   num_components;
      logic [STEP_W-1:0]  step_count;
      logic [CURVE_W-1:0] curve_exponent;
      logic [MODE_W-1:0]  sweep_mode;
      logic [DUR_W-1:0]   sweep_duration;
   } cfg_type;

   typedef enum logic {OP_LOAD, OP_TICK} op_type;

   typedef struct packed {
      op_type       op;
      req_item_type req;
   } front_item_type;

   typedef enum logic [1:0] {K_ZERO, K_ONE, K_CALC} kcls_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DT_WAIT, ST_M_WAIT, ST_NORM, ST_SQ_MUL, ST_SQ_ADJ, ST_LG_MUL,
      ST_EXP, ST_ROOT_MUL, ST_ROOT_ADJ, ST_KFIN, ST_COMP_RD, ST_COMP_MUL,
      ST_COMP_PUSH, ST_SCHED
   } eng_state_type;

   typedef logic [24:0][DATA_W-1:0] root_tab_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] b;
      n   = n_in;
      res = '0;
      b   = 64'h4000_0000_0000_0000;
      for (int k = 0; k < 32; k++) begin
         if (n >= res + b) begin
            n   = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic root_tab_type build_roots();
      root_tab_type t;
      logic [63:0]  q;
      t    = '0;
      q    = isqrt64(64'h8000_0000_0000_0000);
      t[1] = q[31:0];
      for (int i = 1; i < 24; i++) begin
         q        = isqrt64({t[i], 32'h0});
         t[i + 1] = q[31:0];
      end
      return t;
   endfunction

   localparam root_tab_type ROOTS = build_roots();

endpackage
`default_nettype wire

[rtl/pms_front.sv]
// input side: accepts transactions, classifies them and queues them for the engine
`default_nettype none
module pms_front
   import pms_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_push,
   output logic                req_full,
   input  wire req_item_type   req_item,
   output logic                q_valid,
   output front_item_type      q_item,
   input  wire logic           q_pop
);

   front_item_type    mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;
   front_item_type    new_item;

   assign req_full = (count_ff == 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = mem_ff[rd_ptr_ff];
   assign do_push  = req_push && !req_full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      new_item.req = req_item;
      new_item.op  = (req_item.cmd == CMD_LOAD) ? OP_LOAD : OP_TICK;
      wr_ptr_in    = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in    = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in     = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

[rtl/pms_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module pms_div
   import pms_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIV_CNT_W-1:0] count,
   input  wire logic [STEP_W-1:0]    divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     num_ff, num_in;
   logic [STEP_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]    den_ff, den_in;
   logic [STEP_W:0]      sh;
   logic                 ge;

   assign done     = done_ff;
   assign quotient = num_ff;

   always_comb begin
      sh      = {rem_ff, num_ff[DIV_W-1]};
      ge      = (sh >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = count;
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? STEP_W'(sh - {1'b0, den_ff}) : sh[STEP_W-1:0];
         num_in = {num_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule
`default_nettype wire

[rtl/pms_engine.sv]
// back end: sweep state, easing unit, endpoint tables and result generation
`default_nettype none
module pms_engine
   import pms_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cfg_type        cfg,
   input  wire logic           q_valid,
   input  wire front_item_type q_item,
   output logic                q_pop,
   output logic                out_push,
   output rsp_item_type        out_item,
   input  wire logic           out_full
);

   eng_state_type      state_ff, state_in;
   logic [STEP_W-1:0]  pos_ff, pos_in;
   logic               down_ff, down_in;
   logic               started_ff, started_in;
   logic               fin_ff, fin_in;
   logic               emit_ff, emit_in;
   kcls_type           kcls_ff, kcls_in;
   logic [DATA_W-1:0]  now_ff, now_in;
   logic [DATA_W-1:0]  wake_ff, wake_in;
   logic [DATA_W-1:0]  m_ff, m_in;
   logic [4:0]         s_ff, s_in;
   logic [DATA_W-1:0]  x_ff, x_in;
   logic [23:0]        f_ff, f_in;
   logic [4:0]         i_ff, i_in;
   logic [64:0]        mult_ff, mult_in;
   logic [4:0]         ip_ff, ip_in;
   logic [23:0]        fr_ff, fr_in;
   logic [DATA_W-1:0]  r_ff, r_in;
   logic               rone_ff, rone_in;
   logic [4:0]         j_ff, j_in;
   logic [DATA_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]   comp_ff, comp_in;
   logic               neg_ff, neg_in;

   logic [DATA_W-1:0]  from_mem [MAX_COMPONENTS];
   logic [DATA_W-1:0]  to_mem [MAX_COMPONENTS];
   logic [DATA_W-1:0]  from_rd_ff;
   logic [DATA_W-1:0]  to_rd_ff;
   logic               mem_we;

   logic               div_start;
   logic [DIV_W-1:0]   div_dividend;
   logic [DIV_CNT_W-1:0] div_count;
   logic               div_done;
   logic [DIV_W-1:0]   div_quot;

   logic [STEP_W-1:0]  den;
   logic [CNT_W-1:0]   ncomp;
   logic [STEP_W:0]    p1;
   logic [STEP_W-1:0]  np;
   logic               nd, nf;
   logic [32:0]        t_sq;
   logic [29:0]        lg;
   logic [33:0]        e_val;
   logic [4:0]         fidx;
   logic [32:0]        rfull, rsh;
   logic [32:0]        dval, mag;
   logic [DATA_W-1:0]  stp;

   pms_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .count    (div_count),
      .divisor  (den),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign den   = (cfg.step_count > STEP_W'(1)) ? cfg.step_count - 1'b1 : STEP_W'(1);
   assign ncomp = (cfg.num_components > CNT_W'(MAX_COMPONENTS))
                  ? CNT_W'(MAX_COMPONENTS) : cfg.num_components;

   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      down_in    = down_ff;
      started_in = started_ff;
      fin_in     = fin_ff;
      emit_in    = emit_ff;
      kcls_in    = kcls_ff;
      now_in     = now_ff;
      wake_in    = wake_ff;
      m_in       = m_ff;
      s_in       = s_ff;
      x_in       = x_ff;
      f_in       = f_ff;
      i_in       = i_ff;
      mult_in    = mult_ff;
      ip_in      = ip_ff;
      fr_in      = fr_ff;
      r_in       = r_ff;
      rone_in    = rone_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      comp_in    = comp_ff;
      neg_in     = neg_ff;
      q_pop      = 1'b0;
      mem_we     = 1'b0;
      div_start  = 1'b0;
      div_dividend = {cfg.sweep_duration, 20'h0};
      div_count  = DIV_CNT_W'(DUR_W);
      out_push   = 1'b0;
      out_item   = '0;
      out_item.event_time = now_ff;
      p1    = '0;
      np    = '0;
      nd    = 1'b0;
      nf    = 1'b0;
      t_sq  = mult_ff[63:31];
      lg    = ((30'(s_ff) + 30'd1) << 24) - 30'(f_ff);
      e_val = mult_ff[45:12];
      fidx  = 5'(5'd24 - j_ff);
      rfull = rone_ff ? 33'h1_0000_0000 : {1'b0, r_ff};
      rsh   = rfull >> ip_ff;
      dval  = {to_rd_ff[DATA_W-1], to_rd_ff} - {from_rd_ff[DATA_W-1], from_rd_ff};
      mag   = dval[32] ? 33'(-dval) : dval;
      stp   = mult_ff[62:31];

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.op == OP_LOAD) begin
                  mem_we = 1'b1;
               end else begin
                  now_in = q_item.req.now_time;
                  fin_in = 1'b0;
                  if (!started_ff) begin
                     started_in = 1'b1;
                     pos_in     = '0;
                     down_in    = 1'b0;
                     emit_in    = 1'b1;
                     kcls_in    = K_ZERO;
                  end else if (q_item.req.transport_running) begin
                     emit_in = 1'b1;
                     if (down_ff) begin
                        p1 = (pos_ff != '0) ? {1'b0, pos_ff} - 1'b1 : '0;
                     end else begin
                        p1 = {1'b0, pos_ff} + 1'b1;
                     end
                     np = p1[STEP_W-1:0];
                     nd = down_ff;
                     if (p1 >= {1'b0, den}) begin
                        if (cfg.sweep_mode == MODE_PINGPONG) begin
                           np = den;
                           nd = 1'b1;
                        end else if (cfg.sweep_mode == MODE_LOOP) begin
                           np = '0;
                        end else begin
                           np = den;
                           nf = 1'b1;
                        end
                     end else if (p1 == '0 && down_ff) begin
                        nd = 1'b0;
                     end
                     pos_in  = np;
                     down_in = nd;
                     fin_in  = nf;
                     if (nf) begin
                        kcls_in = K_ONE;
                     end else if (np == '0) begin
                        kcls_in = K_ZERO;
                     end else if (np >= den) begin
                        kcls_in = K_ONE;
                     end else begin
                        kcls_in = K_CALC;
                     end
                  end else begin
                     emit_in = 1'b0;
                  end
                  div_start = 1'b1;
                  state_in  = ST_DT_WAIT;
               end
            end
         end
         ST_DT_WAIT: begin
            if (div_done) begin
               wake_in = fin_ff ? '0 : now_ff + DATA_W'(div_quot[DUR_W-1:0]);
               comp_in = '0;
               if (!emit_ff || ncomp == '0) begin
                  state_in = ST_SCHED;
               end else begin
                  unique case (kcls_ff)
                     K_ZERO: begin
                        k_in     = '0;
                        state_in = ST_COMP_RD;
                     end
                     K_ONE: begin
                        k_in     = ONE_Q31;
                        state_in = ST_COMP_RD;
                     end
                     default: begin
                        div_start    = 1'b1;
                        div_dividend = {pos_ff, 32'h0};
                        div_count    = DIV_CNT_W'(DIV_W);
                        state_in     = ST_M_WAIT;
                     end
                  endcase
               end
            end
         end
         ST_M_WAIT: begin
            if (div_done) begin
               m_in = div_quot[DATA_W-1:0];
               if (cfg.curve_exponent == CURVE_LINEAR) begin
                  k_in     = {1'b0, div_quot[DATA_W-1:1]};
                  state_in = ST_COMP_RD;
               end else begin
                  s_in     = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            if (m_ff[DATA_W-1]) begin
               x_in     = m_ff;
               i_in     = 5'd23;
               f_in     = '0;
               state_in = ST_SQ_MUL;
            end else begin
               m_in = {m_ff[DATA_W-2:0], 1'b0};
               s_in = s_ff + 1'b1;
            end
         end
         ST_SQ_MUL: begin
            mult_in  = 65'(x_ff * x_ff);
            state_in = ST_SQ_ADJ;
         end
         ST_SQ_ADJ: begin
            if (t_sq[32]) begin
               x_in       = t_sq[32:1];
               f_in[i_ff] = 1'b1;
            end else begin
               x_in = t_sq[31:0];
            end
            if (i_ff == '0) begin
               state_in = ST_LG_MUL;
            end else begin
               i_in     = i_ff - 1'b1;
               state_in = ST_SQ_MUL;
            end
         end
         ST_LG_MUL: begin
            mult_in  = 65'(lg * cfg.curve_exponent);
            state_in = ST_EXP;
         end
         ST_EXP: begin
            if (e_val[33:24] >= 10'd32) begin
               k_in     = '0;
               state_in = ST_COMP_RD;
            end else begin
               ip_in    = e_val[28:24];
               fr_in    = e_val[23:0];
               rone_in  = 1'b1;
               j_in     = 5'd1;
               state_in = ST_ROOT_MUL;
            end
         end
         ST_ROOT_MUL: begin
            if (fr_ff[fidx] && !rone_ff) begin
               mult_in  = 65'(r_ff * ROOTS[j_ff]);
               state_in = ST_ROOT_ADJ;
            end else begin
               if (fr_ff[fidx]) begin
                  r_in    = ROOTS[j_ff];
                  rone_in = 1'b0;
               end
               j_in = j_ff + 1'b1;
               if (j_ff == 5'd24) begin
                  state_in = ST_KFIN;
               end
            end
         end
         ST_ROOT_ADJ: begin
            r_in = mult_ff[63:32];
            j_in = j_ff + 1'b1;
            state_in = (j_ff == 5'd24) ? ST_KFIN : ST_ROOT_MUL;
         end
         ST_KFIN: begin
            k_in     = rsh[32:1];
            state_in = ST_COMP_RD;
         end
         ST_COMP_RD: begin
            state_in = ST_COMP_MUL;
         end
         ST_COMP_MUL: begin
            neg_in   = dval[32];
            mult_in  = 65'(mag * k_ff);
            state_in = ST_COMP_PUSH;
         end
         ST_COMP_PUSH: begin
            out_item.kind        = KIND_VALUE;
            out_item.component   = comp_ff[SLOT_W-1:0];
            out_item.morph_value = neg_ff ? from_rd_ff - stp : from_rd_ff + stp;
            if (!out_full) begin
               out_push = 1'b1;
               comp_in  = comp_ff + 1'b1;
               state_in = (comp_ff + 1'b1 == ncomp) ? ST_SCHED : ST_COMP_RD;
            end
         end
         ST_SCHED: begin
            out_item.kind      = KIND_SCHED;
            out_item.next_wake = wake_ff;
            out_item.finished  = fin_ff;
            out_item.last      = 1'b1;
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pos_ff     <= '0;
         down_ff    <= 1'b0;
         started_ff <= 1'b0;
         fin_ff     <= 1'b0;
         emit_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         down_ff    <= down_in;
         started_ff <= started_in;
         fin_ff     <= fin_in;
         emit_ff    <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      kcls_ff <= kcls_in;
      now_ff  <= now_in;
      wake_ff <= wake_in;
      m_ff    <= m_in;
      s_ff    <= s_in;
      x_ff    <= x_in;
      f_ff    <= f_in;
      i_ff    <= i_in;
      mult_ff <= mult_in;
      ip_ff   <= ip_in;
      fr_ff   <= fr_in;
      r_ff    <= r_in;
      rone_ff <= rone_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      comp_ff <= comp_in;
      neg_ff  <= neg_in;
   end

   // endpoint tables
   always_ff @(posedge clock) begin
      if (mem_we) begin
         from_mem[q_item.req.slot] <= q_item.req.start_value;
         to_mem[q_item.req.slot]   <= q_item.req.end_value;
      end
      from_rd_ff <= from_mem[comp_ff[SLOT_W-1:0]];
      to_rd_ff   <= to_mem[comp_ff[SLOT_W-1:0]];
   end

endmodule
`default_nettype wire

[rtl/pms_rsp_queue.sv]
// two-entry result queue between the engine and the result ports
`default_nettype none
module pms_rsp_queue
   import pms_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_item_type push_item,
   output logic              full,
   output logic              empty,
   output rsp_item_type      head_item,
   input  wire logic         pop
);

   rsp_item_type mem_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

[rtl/preset_morph_sweep_top.sv]
// top level of the preset morph sweep
// a load is written to the endpoint tables when the idle engine pops it; a tick runs the
// duration divider, off the endpoints the phase divider, and with a nonlinear curve the
// normalize, log squaring and exponent steps; one transaction at a time, then a read, a
// multiply and a push per component and one schedule transaction; reset: synchronous,
// clears queues and sweep position and loads the config registers with their defaults
`default_nettype none
`include "assert_macros.svh"
module preset_morph_sweep_top
   import pms_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire req_item_type          req_item,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output rsp_item_type               rsp_item,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type        cfg_ff, cfg_in;
   logic           q_valid;
   front_item_type q_item;
   logic           q_pop;
   logic           eng_push;
   rsp_item_type   eng_item;
   logic           rspq_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_NUM_COMP: cfg_in.num_components = csr_wdata[CNT_W-1:0];
            CSR_STEPS:    cfg_in.step_count     = csr_wdata[STEP_W-1:0];
            CSR_CURVE:    cfg_in.curve_exponent = csr_wdata[CURVE_W-1:0];
            CSR_MODE:     cfg_in.sweep_mode     = csr_wdata[MODE_W-1:0];
            CSR_DURATION: cfg_in.sweep_duration = csr_wdata[DUR_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_components <= '0;
         cfg_ff.step_count     <= STEP_W'(48);
         cfg_ff.curve_exponent <= CURVE_LINEAR;
         cfg_ff.sweep_mode     <= '0;
         cfg_ff.sweep_duration <= DUR_W'(30000);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pms_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   pms_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .out_push (eng_push),
      .out_item (eng_item),
      .out_full (rspq_full)
   );

   pms_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (eng_push),
      .push_item (eng_item),
      .full      (rspq_full),
      .empty     (rsp_empty),
      .head_item (rsp_item),
      .pop       (rsp_pop)
   );

   `PMS_ASSERT_IMP(a_no_push_full, clock, reset, eng_push, !rspq_full)
   `PMS_ASSERT_IMP(a_sched_last, clock, reset,
      !rsp_empty && rsp_item.kind == KIND_SCHED, rsp_item.last)
   `PMS_ASSERT_IMP(a_fin_no_wake, clock, reset,
      !rsp_empty && rsp_item.finished, rsp_item.next_wake == '0)
   `PMS_ASSERT_NXT(a_csr_steps, clock, reset, csr_wr_en && csr_index == CSR_STEPS,
      cfg_ff.step_count == $past(csr_wdata[STEP_W-1:0]))

endmodule
`default_nettype wire

[bench/tb.sv]
// testbench for the preset morph sweep: queue-fed driver, predictor and result checker
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import pms_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_item_type req_item = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_item_type rsp_item;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   preset_morph_sweep_top u_dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_item(req_item),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // predictor state
   logic [CNT_W-1:0]   m_ncomp;
   logic [STEP_W-1:0]  m_steps;
   logic [CURVE_W-1:0] m_curve;
   logic [MODE_W-1:0]  m_mode;
   logic [DUR_W-1:0]   m_dur;
   logic [31:0] from_tab [MAX_COMPONENTS];
   logic [31:0] to_tab [MAX_COMPONENTS];
   logic [31:0] sweep_pos;
   bit sweep_down, sweep_started;
   logic [31:0] half_roots [25];

   req_item_type pending_items[$];
   rsp_item_type expected_morph[$];
   int errors = 0;
   bit quiet = 1'b0;
   bit rx_hold = 1'b0;
   int idle_cnt = 0;
   int tx_gap = 0, rx_gap = 0;

   // sampled handshake state
   logic req_full_s = 1'b0;

   function automatic logic [63:0] int_sqrt(logic [63:0] n_in);
      logic [63:0] n, res, b;
      n = n_in; res = 0; b = 64'h4000_0000_0000_0000;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b); res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] ease_k31(logic [31:0] p, logic [31:0] den);
      logic [63:0] m, x, f, lg, e, r;
      logic [31:0] s, ip, fr;
      if (p == 0) return '0;
      if (p >= den) return ONE_Q31;
      if (m_curve == CURVE_LINEAR) return 32'((64'(p) << 31) / den);
      m = (64'(p) << 32) / den;
      s = 0; f = 0;
      while (m < 64'h8000_0000) begin
         m = m << 1; s++;
      end
      x = m;
      for (int i = 23; i >= 0; i--) begin
         x = (x * x) >> 31;
         if (x >= 64'h1_0000_0000) begin
            x = x >> 1; f[i] = 1'b1;
         end
      end
      lg = (64'(s + 1) << 24) - f;
      e = (lg * m_curve) >> 12;
      ip = 32'(e >> 24);
      fr = 32'(e & 64'hFF_FFFF);
      if (ip >= 32) return '0;
      r = 64'h1_0000_0000;
      for (int i = 1; i <= 24; i++)
         if (fr[24-i]) r = (r * half_roots[i]) >> 32;
      r = r >> ip;
      return 32'(r >> 1);
   endfunction

   task automatic add_expected(rsp_item_type o);
      expected_morph = {expected_morph, o};
   endtask

   task automatic add_pending(req_item_type it);
      pending_items = {pending_items, it};
   endtask

   task automatic predict_values(logic [31:0] k31, logic [31:0] now);
      int n;
      longint a, d, v;
      logic [63:0] mag, stp;
      rsp_item_type o;
      n = (m_ncomp > MAX_COMPONENTS) ? MAX_COMPONENTS : int'(m_ncomp);
      for (int i = 0; i < n; i++) begin
         a = longint'($signed(from_tab[i]));
         d = longint'($signed(to_tab[i])) - a;
         mag = (d < 0) ? 64'(-d) : 64'(d);
         stp = (mag * k31) >> 31;
         v = (d < 0) ? a - longint'(stp) : a + longint'(stp);
         o = '0;
         o.kind = KIND_VALUE; o.component = i[4:0];
         o.morph_value = v[31:0]; o.event_time = now;
         add_expected(o);
      end
   endtask

   task automatic predict_sweep(req_item_type it);
      logic [31:0] den, wake;
      bit fin;
      rsp_item_type o;
      den = (m_steps > 1) ? 32'(m_steps) - 32'd1 : 32'd1;
      wake = it.now_time + 32'(m_dur / den);
      fin = 0;
      if (it.cmd == CMD_LOAD) begin
         from_tab[it.slot] = it.start_value;
         to_tab[it.slot] = it.end_value;
         return;
      end
      if (!sweep_started) begin
         sweep_started = 1; sweep_pos = 0; sweep_down = 0;
         predict_values('0, it.now_time);
      end else if (it.transport_running) begin
         if (sweep_down) begin
            if (sweep_pos > 0) sweep_pos--;
         end else begin
            sweep_pos++;
         end
         if (sweep_pos >= den) begin
            if (m_mode == MODE_PINGPONG) begin
               sweep_pos = den; sweep_down = 1;
            end else if (m_mode == MODE_LOOP) begin
               sweep_pos = 0;
            end else begin
               sweep_pos = den; fin = 1; wake = 0;
            end
         end else if (sweep_pos == 0 && sweep_down) begin
            sweep_down = 0;
         end
         sweep_pos = sweep_pos & 32'h3FF;
         predict_values(fin ? ONE_Q31 : ease_k31(sweep_pos, den), it.now_time);
      end
      o = '0;
      o.kind = KIND_SCHED; o.event_time = it.now_time;
      o.next_wake = wake; o.finished = fin; o.last = 1'b1;
      add_expected(o);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_push && !req_full_s) begin
            void'(pending_items.pop_front());
         end
         if (tx_gap > 0) begin
            tx_gap--;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_push <= 1'b1;
            req_item <= pending_items[0];
            if (!quiet && $urandom_range(0, 19) == 0) tx_gap = $urandom_range(1, 15);
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_full_s <= req_full;
      if (!reset && req_push && !req_full) predict_sweep(req_item);
   end

   // receiver
   always @(negedge clock) begin
      if (rx_gap > 0) begin
         rx_gap--;
         rsp_pop <= 1'b0;
      end else if (rx_hold) begin
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
         if (!quiet && $urandom_range(0, 19) == 0) rx_gap = $urandom_range(1, 15);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type w;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
         if (rsp_pop && !rsp_empty) begin
            if (expected_morph.size() == 0) begin
               report_mismatch("unexpected transaction", 64'(rsp_item), 64'd0);
            end else begin
               w = expected_morph.pop_front();
               if (rsp_item.kind !== w.kind)
                  report_mismatch("kind", 64'(rsp_item.kind), 64'(w.kind));
               if (rsp_item.component !== w.component)
                  report_mismatch("component", 64'(rsp_item.component), 64'(w.component));
               if (rsp_item.morph_value !== w.morph_value)
                  report_mismatch("morph_value", 64'(rsp_item.morph_value),
                                  64'(w.morph_value));
               if (rsp_item.event_time !== w.event_time)
                  report_mismatch("event_time", 64'(rsp_item.event_time), 64'(w.event_time));
               if (rsp_item.next_wake !== w.next_wake)
                  report_mismatch("next_wake", 64'(rsp_item.next_wake), 64'(w.next_wake));
               if (rsp_item.finished !== w.finished)
                  report_mismatch("finished", 64'(rsp_item.finished), 64'(w.finished));
               if (rsp_item.last !== w.last)
                  report_mismatch("last", 64'(rsp_item.last), 64'(w.last));
            end
         end
         if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("[preset_morph_sweep_top] ERROR");
            $finish;
         end
      end
   end

   function automatic req_item_type make_load(int s, logic [31:0] a, logic [31:0] b);
      req_item_type it;
      it = '0;
      it.cmd = CMD_LOAD; it.slot = s[4:0]; it.start_value = a; it.end_value = b;
      it.now_time = $urandom; it.transport_running = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic req_item_type make_tick(logic [31:0] t, bit run);
      req_item_type it;
      it.cmd = ~CMD_LOAD; it.slot = 5'($urandom); it.start_value = $urandom;
      it.end_value = $urandom; it.now_time = t; it.transport_running = run;
      return it;
   endfunction

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_push || expected_morph.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_NUM_COMP: m_ncomp = val[CNT_W-1:0];
         CSR_STEPS:    m_steps = val[STEP_W-1:0];
         CSR_CURVE:    m_curve = val[CURVE_W-1:0];
         CSR_MODE:     m_mode = val[MODE_W-1:0];
         CSR_DURATION: m_dur = val[DUR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic setup(int nc, int st, int cv, int md, int du);
      write_reg(CSR_NUM_COMP, CSR_DATA_W'(nc));
      write_reg(CSR_STEPS, CSR_DATA_W'(st));
      write_reg(CSR_CURVE, CSR_DATA_W'(cv));
      write_reg(CSR_MODE, CSR_DATA_W'(md));
      write_reg(CSR_DURATION, CSR_DATA_W'(du));
   endtask

   initial begin
      logic [31:0] t;
      m_ncomp = 0; m_steps = 48; m_curve = CURVE_LINEAR; m_mode = 0; m_dur = 30000;
      sweep_pos = 0; sweep_down = 0; sweep_started = 0;
      half_roots[0] = 0;
      half_roots[1] = 32'(int_sqrt(64'h8000_0000_0000_0000));
      for (int i = 1; i < 24; i++) half_roots[i+1] = 32'(int_sqrt({half_roots[i], 32'h0}));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: all slots loaded with extremes, first tick, paused, once arrival
      for (int i = 0; i < MAX_COMPONENTS; i++)
         add_pending(make_load(i, (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                               (i % 3) ? 32'h7FFF_FFFF : 32'h8000_0000));
      wait_drained();
      setup(32, 2, 410, 0, 10);
      add_pending(make_tick(32'hFFFF_FFFF, 0));
      add_pending(make_tick(32'h0, 0));
      add_pending(make_tick(32'hFFFF_FFF0, 1));
      add_pending(make_tick(32'h1234, 1));
      wait_drained();
      setup(0, 4, 4096, 3, 3600000);
      add_pending(make_tick(7, 1));
      add_pending(make_tick(8, 1));
      wait_drained();
      // random phases through modes, curves and sizes
      for (int ph = 0; ph < 7; ph++) begin
         int nc;
         nc = (ph == 6) ? 32 : $urandom_range(1, 5);
         if (ph == 0) setup(nc, 512, 32768, MODE_PINGPONG, 3600000);
         else setup(nc, $urandom_range(2, 7), (ph % 2) ? CURVE_LINEAR :
                    $urandom_range(410, 32768), ph % 3, $urandom_range(10, 3600000));
         if (ph == 6) quiet = 1;
         for (int i = 0; i < nc; i++)
            add_pending(make_load(i, $urandom, $urandom));
         if (ph == 6) add_pending(make_load($urandom_range(0, 31), $urandom, $urandom));
         t = $urandom;
         for (int i = 0; i < ((ph == 6) ? 8 : 20); i++) begin
            if ($urandom_range(0, 9) == 0)
               add_pending(make_load($urandom_range(0, nc - 1), $urandom, $urandom));
            t = t + $urandom_range(1, 5000);
            add_pending(make_tick(t, $urandom_range(0, 4) != 0));
         end
         if (ph == 2) begin
            rx_hold = 1;
            repeat (2000) @(posedge clock);
            rx_hold = 0;
         end
         wait_drained();
      end
      if (errors == 0) begin
         $display("[preset_morph_sweep_top] OK");
      end else begin
         $display("[preset_morph_sweep_top] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
